FILE: rtl/apt_pkg.sv
package apt_pkg;

  localparam int DATA_W   = 32;
  localparam int IDX_W    = 4;
  localparam int NUM_COEF = 12;
  localparam int ROWS     = 3;
  localparam int COLS     = 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;

endpackage

FILE: rtl/apt_if.sv
interface apt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [apt_pkg::IDX_W-1:0] coef_index;
  apt_pkg::word_t            coef_value;
  apt_pkg::word_t            in_x;
  apt_pkg::word_t            in_y;
  apt_pkg::word_t            in_z;

  modport source (output valid, op, coef_index, coef_value, in_x, in_y, in_z, input ready);
  modport sink   (input valid, op, coef_index, coef_value, in_x, in_y, in_z, output ready);
endinterface

interface apt_out_if;
  logic           valid;
  logic           ready;
  apt_pkg::word_t out_x;
  apt_pkg::word_t out_y;
  apt_pkg::word_t out_z;
  logic           clipped;

  modport source (output valid, out_x, out_y, out_z, clipped, input ready);
  modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

FILE: rtl/affine_point_transform.sv
// A result is valid on out_m once a point word has passed the stage 1, 2 and 3
// registers. Throughput: one word per cycle while out_m takes each result; a
// coefficient write is taken as one word and applies to every point accepted
// after it. Three multiply/add stages; each holds while the next one is stalled.
// Reset (rst_n low, synchronous): pipeline emptied, coefficients load identity.
module affine_point_transform #(
  parameter int FRAC_BITS  = 16,
  parameter int COEF_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  apt_in_if.sink     in_s,
  apt_out_if.source  out_m
);

  localparam int DW = apt_pkg::DATA_W;
  localparam int CW = (COEF_WIDTH < DW) ? COEF_WIDTH : DW;
  localparam int PW = CW + DW;
  localparam int SW = PW + 2;

  localparam longint CMAX    = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam longint CMIN    = -CMAX - 64'sd1;
  localparam longint ONE_RAW = 64'sd1 <<< FRAC_BITS;
  localparam longint ONE_VAL = (ONE_RAW > CMAX) ? CMAX : ONE_RAW;
  localparam logic signed [CW-1:0] ONE_C = CW'(ONE_VAL);

  localparam logic signed [SW-1:0] SMAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SMIN = SW'(-64'sd2147483648);

  logic signed [CW-1:0] coef_r [apt_pkg::NUM_COEF];
  logic signed [CW-1:0] wr_val;
  logic                 wr_hit;
  logic                 pt_in;

  logic                 v1_r, v2_r, v3_r;
  logic                 ready1, ready2, ready3;
  logic signed [PW-1:0] prod_r [apt_pkg::ROWS][apt_pkg::ROWS];
  logic signed [CW-1:0] tr_r   [apt_pkg::ROWS];
  logic signed [SW-1:0] a_r    [apt_pkg::ROWS];
  logic signed [SW-1:0] b_r    [apt_pkg::ROWS];
  logic signed [DW-1:0] res_r  [apt_pkg::ROWS];
  logic                 clip_r;

  logic signed [SW-1:0] sum_c  [apt_pkg::ROWS];
  logic signed [DW-1:0] sat_c  [apt_pkg::ROWS];
  logic [apt_pkg::ROWS-1:0] clip_c;
  apt_pkg::word_t       pt [apt_pkg::ROWS];

  assign ready3 = !v3_r || out_m.ready;
  assign ready2 = !v2_r || ready3;
  assign ready1 = !v1_r || ready2;
  assign in_s.ready = ready1;

  assign pt_in  = in_s.valid && ready1 && (in_s.op == apt_pkg::OP_XFORM);
  assign wr_hit = in_s.valid && ready1 && (in_s.op == apt_pkg::OP_WRITE) &&
                  (in_s.coef_index < apt_pkg::IDX_W'(apt_pkg::NUM_COEF));

  assign pt[0] = in_s.in_x;
  assign pt[1] = in_s.in_y;
  assign pt[2] = in_s.in_z;

  always_comb begin
    if (longint'(in_s.coef_value) > CMAX) begin
      wr_val = CW'(CMAX);
    end else if (longint'(in_s.coef_value) < CMIN) begin
      wr_val = CW'(CMIN);
    end else begin
      wr_val = CW'(in_s.coef_value);
    end
  end

  // coefficient store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < apt_pkg::NUM_COEF; i++) begin
        coef_r[i] <= ((i == 0) || (i == apt_pkg::COLS + 1) ||
                      (i == 2 * (apt_pkg::COLS + 1))) ? ONE_C : '0;
      end
    end else if (wr_hit) begin
      coef_r[in_s.coef_index] <= wr_val;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_s.valid && (in_s.op == apt_pkg::OP_XFORM);
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (pt_in) begin
      for (int r = 0; r < apt_pkg::ROWS; r++) begin
        for (int c = 0; c < apt_pkg::ROWS; c++) begin
          prod_r[r][c] <= PW'(coef_r[r*apt_pkg::COLS + c]) * PW'(pt[c]);
        end
        tr_r[r] <= coef_r[r*apt_pkg::COLS + apt_pkg::ROWS];
      end
    end
  end

  // stage 2: floor to fraction bits, partial sums
  always_ff @(posedge clk) begin
    if (ready2 && v1_r) begin
      for (int r = 0; r < apt_pkg::ROWS; r++) begin
        a_r[r] <= SW'(prod_r[r][0] >>> FRAC_BITS) + SW'(prod_r[r][1] >>> FRAC_BITS);
        b_r[r] <= SW'(prod_r[r][2] >>> FRAC_BITS) + SW'(tr_r[r]);
      end
    end
  end

  // stage 3: final sum and saturation
  always_comb begin
    for (int r = 0; r < apt_pkg::ROWS; r++) begin
      sum_c[r] = a_r[r] + b_r[r];
      if (sum_c[r] > SMAX) begin
        sat_c[r]  = DW'(SMAX);
        clip_c[r] = 1'b1;
      end else if (sum_c[r] < SMIN) begin
        sat_c[r]  = DW'(SMIN);
        clip_c[r] = 1'b1;
      end else begin
        sat_c[r]  = DW'(sum_c[r]);
        clip_c[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2_r) begin
      for (int r = 0; r < apt_pkg::ROWS; r++) begin
        res_r[r] <= sat_c[r];
      end
      clip_r <= |clip_c;
    end
  end

  assign out_m.valid   = v3_r;
  assign out_m.out_x   = res_r[0];
  assign out_m.out_y   = res_r[1];
  assign out_m.out_z   = res_r[2];
  assign out_m.clipped = clip_r;

  a_wr_lands: assert property (@(posedge clk) disable iff (!rst_n)
    wr_hit |=> coef_r[$past(in_s.coef_index)] == $past(wr_val))
    else $error("coefficient write not stored");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !ready3) |=> v2_r && v3_r)
    else $error("stage 2 word lost under stall");

  a_reset_id: assert property (@(posedge clk)
    !rst_n |=> (coef_r[0] == ONE_C) && (coef_r[1] == '0) && !out_m.valid)
    else $error("reset state wrong");

endmodule
